### design/nsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_pkg: shared types and constants for the named seed derivation block
// FNV-1a and SplitMix64 constants, hash queue sizing, back-end states.
// ----------------------------------------------------------------------------
package nsd_pkg;

   localparam int unsigned SEED_W   = 64;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned HALF_W   = 32;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SEED = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SALT_WORD = 8'd1;

   localparam logic [SEED_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
   // FNV prime is 2^40 + 0x1b3
   localparam int unsigned       FNV_SHIFT = 40;
   localparam logic [8:0]        FNV_LOW   = 9'h1B3;

   localparam logic [SEED_W-1:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [SEED_W-1:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [SEED_W-1:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;

   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = 1;
   localparam int unsigned QCNT_W = 2;

   // five SplitMix rounds per name, counted 0..4
   localparam int unsigned       ROUND_W    = 3;
   localparam logic [ROUND_W-1:0] RND_BASE  = 3'd0;
   localparam logic [ROUND_W-1:0] RND_SALT  = 3'd1;
   localparam logic [ROUND_W-1:0] RND_MIX1  = 3'd2;
   localparam logic [ROUND_W-1:0] RND_HASH  = 3'd3;
   localparam logic [ROUND_W-1:0] RND_LAST  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_M1A,
      ST_M1B,
      ST_M1C,
      ST_M2A,
      ST_M2B,
      ST_M2C,
      ST_DONE
   } nsd_state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } nsd_qctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } nsd_qsts_type;

endpackage
`default_nettype wire

### design/nsd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_front: name byte intake
// Folds one byte per cycle, unless req_full, into the running FNV-1a hash;
// on the last word hands the finished hash to the queue and restarts from the offset basis.
// ----------------------------------------------------------------------------
module nsd_front import nsd_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_push,
   output logic               req_full,
   input  wire  [BYTE_W-1:0]  req_name_byte,
   input  wire                req_has_byte,
   input  wire                req_last,
   input  wire nsd_qsts_type  q_sts,
   output logic               q_push,
   output logic [SEED_W-1:0]  q_hash
);

   logic [SEED_W-1:0] name_hash_ff, name_hash_in;
   logic [SEED_W-1:0] mix_y;
   logic [SEED_W-1:0] folded;
   logic              accept;

   assign req_full = q_sts.full;
   assign accept   = req_push && !q_sts.full;

   always_comb begin
      mix_y  = name_hash_ff ^ {{(SEED_W-BYTE_W){1'b0}}, req_name_byte};
      // multiply by 2^40 + 0x1b3, mod 2^64
      folded = req_has_byte ?
               ((mix_y << FNV_SHIFT) + (mix_y * {{(SEED_W-9){1'b0}}, FNV_LOW})) :
               name_hash_ff;
      name_hash_in = name_hash_ff;
      if (accept) begin
         name_hash_in = req_last ? FNV_BASIS : folded;
      end
   end

   assign q_push = accept && req_last;
   assign q_hash = folded;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_hash_ff <= FNV_BASIS;
      end else begin
         name_hash_ff <= name_hash_in;
      end
   end

endmodule
`default_nettype wire

### design/nsd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_queue: finished name hash queue
// Short FIFO between the intake and the mixing sequencer.
// ----------------------------------------------------------------------------
module nsd_queue import nsd_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire nsd_qctl_type  q_ctl,
   input  wire  [SEED_W-1:0]  wr_data,
   output nsd_qsts_type       q_sts,
   output logic [SEED_W-1:0]  rd_data
);

   logic [SEED_W-1:0] slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_sts.full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_sts.empty = (count_ff == '0);
   assign do_push     = q_ctl.push && !q_sts.full;
   assign do_pop      = q_ctl.pop && !q_sts.empty;
   assign rd_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### design/nsd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_back: SplitMix64 mixing sequencer
// Runs five SplitMix rounds per name hash on one shared 32x32 multiplier,
// each 64-bit constant multiply taken as three partial products.
// ----------------------------------------------------------------------------
module nsd_back import nsd_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire  [SEED_W-1:0]  base_seed,
   input  wire  [SEED_W-1:0]  salt_word,
   input  wire nsd_qsts_type  q_sts,
   input  wire  [SEED_W-1:0]  q_hash,
   output logic               q_pop,
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output logic [SEED_W-1:0]  rsp_derived_seed
);

   nsd_state_type      state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [SEED_W-1:0]  x_ff, x_in;
   logic [SEED_W-1:0]  prod_ff, prod_in;
   logic [SEED_W-1:0]  hold_ff, hold_in;
   logic [SEED_W-1:0]  hash_ff, hash_in;
   logic               out_valid_ff, out_valid_in;
   logic [SEED_W-1:0]  out_seed_ff, out_seed_in;

   logic [HALF_W-1:0]  mul_a, mul_b;
   logic [SEED_W-1:0]  mult;
   logic [SEED_W-1:0]  acc;
   logic [SEED_W-1:0]  added;
   logic [SEED_W-1:0]  rnd_out;
   logic [SEED_W-1:0]  final_seed;
   logic               slot_free;
   logic               load_out;

   assign slot_free = !out_valid_ff || rsp_pop;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_sts.empty) state_in = ST_ADD;
         ST_ADD:  state_in = ST_M1A;
         ST_M1A:  state_in = ST_M1B;
         ST_M1B:  state_in = ST_M1C;
         ST_M1C:  state_in = ST_M2A;
         ST_M2A:  state_in = ST_M2B;
         ST_M2B:  state_in = ST_M2C;
         ST_M2C:  state_in = (round_ff == RND_LAST) ? ST_DONE : ST_ADD;
         ST_DONE: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // multiplier operand selection
   always_comb begin
      mul_a = x_ff[HALF_W-1:0];
      mul_b = SM_MUL1[HALF_W-1:0];
      unique case (state_ff)
         ST_M1A: begin mul_a = x_ff[HALF_W-1:0];      mul_b = SM_MUL1[HALF_W-1:0];      end
         ST_M1B: begin mul_a = x_ff[SEED_W-1:HALF_W]; mul_b = SM_MUL1[HALF_W-1:0];      end
         ST_M1C: begin mul_a = x_ff[HALF_W-1:0];      mul_b = SM_MUL1[SEED_W-1:HALF_W]; end
         ST_M2A: begin mul_a = x_ff[HALF_W-1:0];      mul_b = SM_MUL2[HALF_W-1:0];      end
         ST_M2B: begin mul_a = x_ff[SEED_W-1:HALF_W]; mul_b = SM_MUL2[HALF_W-1:0];      end
         ST_M2C: begin mul_a = x_ff[HALF_W-1:0];      mul_b = SM_MUL2[SEED_W-1:HALF_W]; end
         default: begin mul_a = x_ff[HALF_W-1:0];     mul_b = SM_MUL1[HALF_W-1:0];      end
      endcase
   end

   assign mult  = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   assign acc   = prod_ff + {mult[HALF_W-1:0], {HALF_W{1'b0}}};
   assign added = x_ff + SM_GAMMA;
   assign rnd_out = acc ^ (acc >> 31);

   // zero base gives zero, a zero mix becomes one
   assign final_seed = (base_seed == '0) ? '0 :
                       ((x_ff == '0) ? {{(SEED_W-1){1'b0}}, 1'b1} : x_ff);

   // datapath and outputs
   always_comb begin
      x_in      = x_ff;
      prod_in   = prod_ff;
      hold_in   = hold_ff;
      hash_in   = hash_ff;
      round_in  = round_ff;
      q_pop     = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_sts.empty) begin
               q_pop    = 1'b1;
               hash_in  = q_hash;
               x_in     = base_seed;
               round_in = RND_BASE;
            end
         end
         ST_ADD: x_in = added ^ (added >> 30);
         ST_M1A, ST_M2A: prod_in = mult;
         ST_M1B, ST_M2B: prod_in = acc;
         ST_M1C: x_in = acc ^ (acc >> 27);
         ST_M2C: begin
            round_in = round_ff + 1'b1;
            unique case (round_ff)
               RND_BASE: begin hold_in = rnd_out; x_in = salt_word;         end
               RND_SALT: x_in = hold_ff ^ rnd_out;
               RND_MIX1: begin hold_in = rnd_out; x_in = hash_ff;           end
               RND_HASH: x_in = hold_ff ^ rnd_out;
               RND_LAST: begin x_in = rnd_out; round_in = round_ff;         end
               default:  x_in = rnd_out;
            endcase
         end
         ST_DONE: load_out = slot_free;
         default: x_in = x_ff;
      endcase
   end

   always_comb begin
      out_seed_in  = load_out ? final_seed : out_seed_ff;
      out_valid_in = load_out ? 1'b1 : (out_valid_ff && !rsp_pop);
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_derived_seed = out_seed_ff;

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      hold_ff     <= hold_in;
      hash_ff     <= hash_in;
      out_seed_ff <= out_seed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= RND_BASE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= RND_LAST)
      else $error("round counter out of range");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && !q_sts.empty))
      else $error("hash taken while sequencer busy");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free) |=> (out_valid_ff && state_ff == ST_IDLE))
      else $error("finished seed not loaded into output word");

   a_nonzero_seed: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (out_seed_ff != '0 || $past(base_seed) == '0))
      else $error("zero seed with non-zero base");
`endif

endmodule
`default_nettype wire

### design/named_seed_derivation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// named_seed_derivation: seed derivation from a streamed name
// FNV-1a hash of the name bytes, mixed with base seed and salt through
// SplitMix64 rounds; one derived seed per name.
// ----------------------------------------------------------------------------
// Name bytes are taken one word per clock while req_full is low; req_full
// is raised whenever the two-entry hash queue is full and holds every word.
// Each name is then mixed by a sequencer sharing one 32x32 multiplier over
// five SplitMix rounds, each an add step and two constant multiplies; the
// back end fetches the hash, runs the rounds, then writes the output word
// once it is free, and the intake takes further names until the queue fills.
// Base seed and salt are written through the always-ready csr_ port.
module named_seed_derivation import nsd_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  wire  [BYTE_W-1:0]    req_name_byte,
   input  wire                  req_has_byte,
   input  wire                  req_last,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output logic [SEED_W-1:0]    rsp_derived_seed,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [SEED_W-1:0]    csr_wdata
);

   logic [SEED_W-1:0] base_seed_ff, base_seed_in;
   logic [SEED_W-1:0] salt_word_ff, salt_word_in;
   nsd_qctl_type      q_ctl;
   nsd_qsts_type      q_sts;
   logic [SEED_W-1:0] q_wr_hash, q_rd_hash;
   logic              q_push, q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      base_seed_in = base_seed_ff;
      salt_word_in = salt_word_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_SEED: base_seed_in = csr_wdata;
            CSR_SALT_WORD: salt_word_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_seed_ff <= '0;
         salt_word_ff <= '0;
      end else begin
         base_seed_ff <= base_seed_in;
         salt_word_ff <= salt_word_in;
      end
   end

   assign q_ctl.push = q_push;
   assign q_ctl.pop  = q_pop;

   nsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_name_byte (req_name_byte),
      .req_has_byte  (req_has_byte),
      .req_last      (req_last),
      .q_sts         (q_sts),
      .q_push        (q_push),
      .q_hash        (q_wr_hash)
   );

   nsd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_ctl   (q_ctl),
      .wr_data (q_wr_hash),
      .q_sts   (q_sts),
      .rd_data (q_rd_hash)
   );

   nsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .base_seed        (base_seed_ff),
      .salt_word        (salt_word_ff),
      .q_sts            (q_sts),
      .q_hash           (q_rd_hash),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_derived_seed (rsp_derived_seed)
   );

endmodule
`default_nettype wire
